// File: src/rfd_pkg.sv
// Shared types and constants for the readout frame deframer.
// Holds parse phases, result codes and the result record; no dependencies.
`timescale 1ns / 1ps

package rfd_pkg;

  localparam int LENGTH_BITS = 16;
  localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 32'd1);

  localparam logic [7:0]  START_BYTE   = 8'h60;
  localparam logic [7:0]  HEADER_MARK  = 8'h58;
  localparam logic [7:0]  BEGIN_MARK   = 8'hbb;
  localparam logic [7:0]  END_MARK     = 8'hee;
  localparam logic [31:0] END_COOKIE   = 32'h8765_4321;
  localparam logic [15:0] MIN_PACKET   = 16'd19;
  localparam logic [15:0] MIN_WORDS    = 16'd4;
  localparam logic [15:0] SKIP_BYTES   = 16'd3;
  localparam logic [15:0] FRAME_OVERHEAD = 16'd3;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_FRAME   = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // packet status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_START  = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd2;
  localparam logic [2:0] ST_BAD_HEADER = 3'd3;
  localparam logic [2:0] ST_NO_BEGIN   = 3'd4;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd5;
  localparam logic [2:0] ST_NO_COOKIE  = 3'd6;
  localparam logic [2:0] ST_NO_END     = 3'd7;

  // output queue
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SKIP    = 3'd1,
    PH_HEADER  = 3'd2,
    PH_BEGIN   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_COOKIE  = 3'd5,
    PH_END     = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic [15:0] count;
    logic [2:0]  status;
    logic [15:0] left;
  } result_t;

endpackage

// File: src/readout_frame_deframer.sv
// Readout packet deframer: byte parser with a small output queue.
// Depends on rfd_pkg.
//
// Usage:
//   Input channel carries one packet byte per transfer (data_byte), with
//   packet_start marking the first byte and packet_length sampled with it.
//   Output channel carries result records: payload words, frame accepted
//   markers with the payload word count, and at most one packet status per packet.
// Queueing: results of a byte enter the output queue at the edge that
//   accepts the byte; the output reads the registered queue head.
// Throughput: one byte per cycle while in_stall is low. A byte yields at
//   most two results (the last frame's accept marker and the ok status);
//   the 4-entry output queue drains one result per cycle while out_stall
//   is low, and in_stall rises while it holds more than two entries.
// Reset: the parser returns to idle and the queue empties; bytes are
//   ignored until the next packet_start.
// Receiver stall: the head result holds on the output; once the queue
//   holds more than two entries, in_stall holds the byte stream back.
`timescale 1ns / 1ps

module readout_frame_deframer import rfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_start,
  input  logic [15:0] packet_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [31:0] payload_word,
  output logic [15:0] frame_word_count,
  output logic [2:0]  packet_status,
  output logic [15:0] leftover_bytes
);

  phase_t      phase, phase_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] packet_size, packet_size_next;
  logic [23:0] word_asm, word_asm_next;
  logic [15:0] words_left, words_left_next;
  logic [15:0] payload_total, payload_total_next;

  logic        accept;
  logic        parsing;
  logic [15:0] size_in;
  logic        bad_start, too_short, no_frames;
  logic [15:0] pos;
  logic [1:0]  byte_lane;
  logic        word_done;
  logic [31:0] full_word;
  logic [15:0] total_words, word_idx, rem, rem_m1, rem_x4, rem_m1_x4;
  logic [15:0] len_body;
  logic        len_bad;

  result_t     res0, res1;
  logic [1:0]  n_wr;

  result_t               queue [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]  q_count;
  logic                  q_read;

  assign accept    = in_valid && !in_stall;
  assign parsing   = (phase != PH_IDLE) && (phase != PH_DONE);
  assign size_in   = packet_length & LEN_MASK;
  assign bad_start = data_byte != START_BYTE;
  assign too_short = size_in < MIN_PACKET;
  assign no_frames = ((size_in - SKIP_BYTES) >> 2) <= MIN_WORDS;

  assign pos       = bytes_seen;
  assign byte_lane = 2'(pos[1:0] + 2'd1);
  assign word_done = (pos >= SKIP_BYTES) && (byte_lane == 2'd3);
  assign full_word = {data_byte, word_asm};

  assign total_words = (packet_size - SKIP_BYTES) >> 2;
  assign word_idx    = (pos - SKIP_BYTES) >> 2;
  assign rem         = total_words - word_idx;
  assign rem_m1      = rem - 16'd1;
  assign rem_x4      = {rem[13:0], 2'b00};
  assign rem_m1_x4   = {rem_m1[13:0], 2'b00};
  assign len_body    = payload_total - FRAME_OVERHEAD;
  assign len_bad     = (payload_total < FRAME_OVERHEAD) || (rem == 16'd0) ||
                       (payload_total > rem);

  // next state
  always_comb begin
    phase_next         = phase;
    bytes_seen_next    = bytes_seen;
    packet_size_next   = packet_size;
    word_asm_next      = word_asm;
    words_left_next    = words_left;
    payload_total_next = payload_total;
    if (accept) begin
      if (packet_start) begin
        packet_size_next   = size_in;
        bytes_seen_next    = 16'd1;
        word_asm_next      = '0;
        words_left_next    = '0;
        payload_total_next = '0;
        phase_next = (bad_start || too_short || no_frames) ? PH_DONE : PH_SKIP;
      end else if (parsing) begin
        bytes_seen_next = (pos + 16'd1) & LEN_MASK;
        if (pos < SKIP_BYTES) begin
          if (pos == SKIP_BYTES - 16'd1) begin
            phase_next = PH_HEADER;
          end
        end else if (!word_done) begin
          word_asm_next = word_asm | ({16'b0, data_byte} << {byte_lane, 3'b000});
        end else begin
          word_asm_next = '0;
          case (phase)
            PH_HEADER: begin
              if (full_word[7:0] != HEADER_MARK) begin
                phase_next = PH_DONE;
              end else begin
                // length field is big-endian in bytes 1 and 2
                payload_total_next = {full_word[15:8], full_word[23:16]};
                phase_next         = PH_BEGIN;
              end
            end
            PH_BEGIN: begin
              if (full_word[31:24] != BEGIN_MARK || len_bad) begin
                phase_next = PH_DONE;
              end else begin
                payload_total_next = len_body;
                words_left_next    = len_body;
                phase_next = (len_body != 16'd0) ? PH_PAYLOAD : PH_COOKIE;
              end
            end
            PH_PAYLOAD: begin
              words_left_next = words_left - 16'd1;
              if (words_left == 16'd1) begin
                phase_next = PH_COOKIE;
              end
            end
            PH_COOKIE: begin
              phase_next = (full_word != END_COOKIE) ? PH_DONE : PH_END;
            end
            PH_END: begin
              if (full_word[31:24] != END_MARK || rem_m1 <= MIN_WORDS) begin
                phase_next = PH_DONE;
              end else begin
                phase_next = PH_HEADER;
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
    end
  end

  // results of the accepted byte
  always_comb begin
    res0 = '0;
    res1 = '0;
    n_wr = 2'd0;
    if (accept) begin
      if (packet_start) begin
        if (bad_start) begin
          res0.kind   = KIND_STATUS;
          res0.status = ST_BAD_START;
          res0.left   = size_in;
          n_wr        = 2'd1;
        end else if (too_short) begin
          res0.kind   = KIND_STATUS;
          res0.status = ST_TOO_SHORT;
          res0.left   = size_in;
          n_wr        = 2'd1;
        end else if (no_frames) begin
          res0.kind   = KIND_STATUS;
          res0.status = ST_OK;
          n_wr        = 2'd1;
        end
      end else if (parsing && word_done) begin
        case (phase)
          PH_HEADER: begin
            if (full_word[7:0] != HEADER_MARK) begin
              res0.kind   = KIND_STATUS;
              res0.status = ST_BAD_HEADER;
              res0.left   = rem_x4;
              n_wr        = 2'd1;
            end
          end
          PH_BEGIN: begin
            if (full_word[31:24] != BEGIN_MARK) begin
              res0.kind   = KIND_STATUS;
              res0.status = ST_NO_BEGIN;
              res0.left   = rem_x4;
              n_wr        = 2'd1;
            end else if (len_bad) begin
              res0.kind   = KIND_STATUS;
              res0.status = ST_BAD_LENGTH;
              res0.left   = rem_m1_x4;
              n_wr        = 2'd1;
            end
          end
          PH_PAYLOAD: begin
            res0.kind = KIND_PAYLOAD;
            res0.word = full_word;
            n_wr      = 2'd1;
          end
          PH_COOKIE: begin
            if (full_word != END_COOKIE) begin
              res0.kind   = KIND_STATUS;
              res0.status = ST_NO_COOKIE;
              res0.left   = rem_x4;
              n_wr        = 2'd1;
            end
          end
          PH_END: begin
            if (full_word[31:24] != END_MARK) begin
              res0.kind   = KIND_STATUS;
              res0.status = ST_NO_END;
              res0.left   = rem_x4;
              n_wr        = 2'd1;
            end else begin
              res0.kind  = KIND_FRAME;
              res0.count = payload_total;
              n_wr       = 2'd1;
              // last frame of the packet: close with ok status
              if (rem_m1 <= MIN_WORDS) begin
                res1.kind   = KIND_STATUS;
                res1.status = ST_OK;
                n_wr        = 2'd2;
              end
            end
          end
          default: begin
            n_wr = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bytes_seen    <= '0;
      packet_size   <= '0;
      word_asm      <= '0;
      words_left    <= '0;
      payload_total <= '0;
    end else begin
      phase         <= phase_next;
      bytes_seen    <= bytes_seen_next;
      packet_size   <= packet_size_next;
      word_asm      <= word_asm_next;
      words_left    <= words_left_next;
      payload_total <= payload_total_next;
    end
  end

  // output queue
  assign q_read    = out_valid && !out_stall;
  assign out_valid = q_count != '0;
  assign in_stall  = q_count > QCNT_BITS'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= QPTR_BITS'(wr_ptr + QPTR_BITS'(n_wr));
      rd_ptr  <= QPTR_BITS'(rd_ptr + QPTR_BITS'(q_read));
      q_count <= QCNT_BITS'(q_count + QCNT_BITS'(n_wr) - QCNT_BITS'(q_read));
    end
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (n_wr == 2'd2) begin
      queue[QPTR_BITS'(wr_ptr + 1'b1)] <= res1;
    end
  end

  assign result_kind      = queue[rd_ptr].kind;
  assign payload_word     = queue[rd_ptr].word;
  assign frame_word_count = queue[rd_ptr].count;
  assign packet_status    = queue[rd_ptr].status;
  assign leftover_bytes   = queue[rd_ptr].left;

endmodule

// File: src/rfd_checker.sv
// Port-level checks for the readout frame deframer, bound to the top level.
// Depends on rfd_pkg.
`timescale 1ns / 1ps

module rfd_checker import rfd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  result_kind,
  input logic [31:0] payload_word,
  input logic [15:0] frame_word_count,
  input logic [2:0]  packet_status,
  input logic [15:0] leftover_bytes
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) &&
      $stable(payload_word) && $stable(frame_word_count) &&
      $stable(packet_status) && $stable(leftover_bytes))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind != 2'd3)
    else $error("undefined result kind");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_PAYLOAD |->
      frame_word_count == 16'd0 && packet_status == ST_OK && leftover_bytes == 16'd0)
    else $error("payload transfer carries stray fields");

  a_ok_no_leftover: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_STATUS && packet_status == ST_OK |->
      leftover_bytes == 16'd0 && payload_word == 32'd0)
    else $error("ok status with leftover bytes");

endmodule

bind readout_frame_deframer rfd_checker u_rfd_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .result_kind      (result_kind),
  .payload_word     (payload_word),
  .frame_word_count (frame_word_count),
  .packet_status    (packet_status),
  .leftover_bytes   (leftover_bytes)
);

// File: tb/testbench.sv
// Testbench for readout_frame_deframer: streams readout packets byte by byte
// and checks every result against a predictor held in this file.
// Depends on rfd_pkg and the readout_frame_deframer RTL.
`timescale 1ns / 1ps

module testbench;
  import rfd_pkg::*;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int RANDOM_BYTES = 1200;

  typedef logic [7:0] byte_queue_t[$];

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        packet_start;
  logic [15:0] packet_length;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [31:0] payload_word;
  logic [15:0] frame_word_count;
  logic [2:0]  packet_status;
  logic [15:0] leftover_bytes;

  result_t     awaited_results[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          packet_bytes_sent = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int          stall_left = 0;
  int          stall_pick;

  // predictor state
  phase_t      pred_phase = PH_IDLE;
  int unsigned pred_seen = 0;
  int unsigned pred_size = 0;
  int unsigned pred_asm = 0;
  int unsigned pred_words_left = 0;
  int unsigned pred_frame_words = 0;

  readout_frame_deframer DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .packet_start     (packet_start),
    .packet_length    (packet_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .payload_word     (payload_word),
    .frame_word_count (frame_word_count),
    .packet_status    (packet_status),
    .leftover_bytes   (leftover_bytes)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void post_result(logic [1:0] kind, logic [31:0] word,
                                      logic [15:0] count, logic [2:0] status,
                                      logic [15:0] left);
    result_t r;
    r.kind   = kind;
    r.word   = word;
    r.count  = count;
    r.status = status;
    r.left   = left;
    awaited_results.push_back(r);
  endfunction

  function automatic void end_packet(logic [2:0] status, logic [15:0] left);
    post_result(KIND_STATUS, 32'd0, 16'd0, status, left);
    pred_phase = PH_DONE;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic start, logic [15:0] len);
    int unsigned pos, k, w, rem, total, flen;
    if (start) begin
      pred_size        = 32'(len & LEN_MASK);
      pred_seen        = 1;
      pred_asm         = 0;
      pred_words_left  = 0;
      pred_frame_words = 0;
      if (b != START_BYTE)
        end_packet(ST_BAD_START, 16'(pred_size));
      else if (pred_size < MIN_PACKET)
        end_packet(ST_TOO_SHORT, 16'(pred_size));
      else if (((pred_size - SKIP_BYTES) >> 2) <= MIN_WORDS)
        end_packet(ST_OK, 16'd0);
      else
        pred_phase = PH_SKIP;
      return;
    end
    if (pred_phase == PH_IDLE || pred_phase == PH_DONE)
      return;

    pos       = pred_seen;
    pred_seen = (pos + 1) & 32'(LEN_MASK);
    if (pos < SKIP_BYTES) begin
      if (pos == SKIP_BYTES - 1)
        pred_phase = PH_HEADER;
      return;
    end

    // gather three bytes, act on the fourth
    k = (pos - SKIP_BYTES) & 3;
    if (k < 3) begin
      pred_asm = (pred_asm | (32'(b) << (8 * k))) & 32'h00ff_ffff;
      return;
    end
    w        = pred_asm | (32'(b) << 24);
    pred_asm = 0;
    total    = (pred_size - SKIP_BYTES) >> 2;
    rem      = total - ((pos - SKIP_BYTES) >> 2);

    case (pred_phase)
      PH_HEADER: begin
        if (w[7:0] != HEADER_MARK) begin
          end_packet(ST_BAD_HEADER, 16'(rem * 4));
        end else begin
          pred_frame_words = {16'd0, w[15:8], w[23:16]};
          pred_phase       = PH_BEGIN;
        end
      end
      PH_BEGIN: begin
        flen = pred_frame_words;
        if (w[31:24] != BEGIN_MARK) begin
          end_packet(ST_NO_BEGIN, 16'(rem * 4));
        end else if (flen < FRAME_OVERHEAD || rem < 1 ||
                     (flen - FRAME_OVERHEAD) + 2 > rem - 1) begin
          end_packet(ST_BAD_LENGTH, 16'((rem - 1) * 4));
        end else begin
          pred_frame_words = flen - FRAME_OVERHEAD;
          pred_words_left  = pred_frame_words;
          if (pred_words_left != 0)
            pred_phase = PH_PAYLOAD;
          else
            pred_phase = PH_COOKIE;
        end
      end
      PH_PAYLOAD: begin
        post_result(KIND_PAYLOAD, w, 16'd0, ST_OK, 16'd0);
        pred_words_left = (pred_words_left - 1) & 32'h0000_ffff;
        if (pred_words_left == 0)
          pred_phase = PH_COOKIE;
      end
      PH_COOKIE: begin
        if (w != END_COOKIE)
          end_packet(ST_NO_COOKIE, 16'(rem * 4));
        else
          pred_phase = PH_END;
      end
      PH_END: begin
        if (w[31:24] != END_MARK) begin
          end_packet(ST_NO_END, 16'(rem * 4));
        end else begin
          post_result(KIND_FRAME, 32'd0, 16'(pred_frame_words), ST_OK, 16'd0);
          if (rem - 1 > MIN_WORDS)
            pred_phase = PH_HEADER;
          else
            end_packet(ST_OK, 16'd0);
        end
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------ result check

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with nothing awaited: kind %0d status %0d",
               result_kind, packet_status);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
          fail_count++;
        end
        if (payload_word !== want.word) begin
          $error("payload_word: expected %h, got %h", want.word, payload_word);
          fail_count++;
        end
        if (frame_word_count !== want.count) begin
          $error("frame_word_count: expected %0d, got %0d", want.count,
                 frame_word_count);
          fail_count++;
        end
        if (packet_status !== want.status) begin
          $error("packet_status: expected %0d, got %0d", want.status,
                 packet_status);
          fail_count++;
        end
        if (leftover_bytes !== want.left) begin
          $error("leftover_bytes: expected %0d, got %0d", want.left,
                 leftover_bytes);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls: mostly short, a few long, no new ones while quiet
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!rx_quiet && $urandom_range(99) < 25) begin
      stall_pick = $urandom_range(99);
      if (stall_pick < 80)
        stall_left = $urandom_range(1, 0);
      else if (stall_pick < 95)
        stall_left = $urandom_range(7, 2);
      else
        stall_left = $urandom_range(39, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic int sender_gap();
    int r;
    if (tx_quiet)
      return 0;
    r = $urandom_range(99);
    if (r < 60)
      return 0;
    if (r < 88)
      return $urandom_range(3, 1);
    if (r < 97)
      return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(logic [7:0] b, logic s, logic [15:0] len);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    packet_start  <= s;
    packet_length <= len;
    do @(posedge clk); while (in_stall);
    parse_byte(b, s, len);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_results.size() != 0);
  endtask

  function automatic void push_word(ref byte_queue_t q, input logic [31:0] w);
    for (int i = 0; i < 4; i++)
      q.push_back(w[8*i +: 8]);
  endfunction

  function automatic int pick_payload_size();
    int r;
    r = $urandom_range(99);
    if (r < 85)
      return $urandom_range(6, 0);
    if (r < 97)
      return $urandom_range(20, 7);
    return $urandom_range(120, 40);
  endfunction

  function automatic logic [31:0] pick_payload_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // npay < 0 picks sizes at random; bad_len < 0 means one word more than fits
  function automatic void build_packet(ref byte_queue_t q, input int nframes,
                                       input int npay, input logic [2:0] fault,
                                       input int fault_at, input int bad_len,
                                       input int tail_words);
    int          n;
    logic [15:0] flen;
    logic [7:0]  mark;
    logic [31:0] cookie;
    q.delete();
    q.push_back(START_BYTE);
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    for (int f = 0; f < nframes; f++) begin
      n    = (npay < 0) ? pick_payload_size() : npay;
      flen = 16'(n + FRAME_OVERHEAD);
      if (f == fault_at && fault == ST_BAD_LENGTH)
        flen = (bad_len < 0) ? 16'(n + 4) : 16'(bad_len);
      mark = HEADER_MARK;
      if (f == fault_at && fault == ST_BAD_HEADER)
        mark = mark ^ 8'($urandom_range(255, 1));
      push_word(q, {8'($urandom), flen[7:0], flen[15:8], mark});
      mark = BEGIN_MARK;
      if (f == fault_at && fault == ST_NO_BEGIN)
        mark = mark ^ 8'($urandom_range(255, 1));
      push_word(q, {mark, 24'($urandom)});
      for (int i = 0; i < n; i++)
        push_word(q, pick_payload_word());
      cookie = END_COOKIE;
      if (f == fault_at && fault == ST_NO_COOKIE)
        cookie[$urandom_range(31)] = ~cookie[$urandom_range(31)];
      if (f == fault_at && fault == ST_NO_COOKIE && cookie == END_COOKIE)
        cookie = ~cookie;
      push_word(q, cookie);
      mark = END_MARK;
      if (f == fault_at && fault == ST_NO_END)
        mark = mark ^ 8'($urandom_range(255, 1));
      push_word(q, {mark, 24'($urandom)});
    end
    for (int i = 0; i < tail_words; i++)
      push_word(q, $urandom);
    repeat ($urandom_range(3)) q.push_back(8'($urandom));
  endfunction

  // declared < 0 uses the real size; count < 0 sends every byte
  task automatic send_packet(ref byte_queue_t q, input int declared = -1,
                             input int count = -1);
    int n;
    n = (count < 0) ? q.size() : count;
    for (int i = 0; i < n; i++) begin
      if (i == 0)
        send_byte(q[0], 1'b1, (declared < 0) ? 16'(q.size()) : 16'(declared));
      else
        send_byte(q[i], 1'b0, 16'($urandom));
      packet_bytes_sent++;
    end
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_start_checks();
    send_byte(START_BYTE, 1'b0, 16'd40);       // no packet yet: ignored
    send_byte(8'h61, 1'b1, 16'hffff);          // bad start byte
    send_byte(8'h00, 1'b0, 16'h0000);          // after the end: ignored
    send_byte(8'hff, 1'b1, 16'd0);             // start byte wins over size
    send_byte(START_BYTE, 1'b1, 16'd0);        // too short
    send_byte(START_BYTE, 1'b1, MIN_PACKET - 16'd1);
    send_byte(START_BYTE, 1'b1, MIN_PACKET);   // four words: ok at once
    send_byte(8'h5a, 1'b0, 16'hffff);
    send_byte(START_BYTE, 1'b1, 16'd22);
  endtask

  task automatic test_well_formed_frames();
    byte_queue_t q;
    build_packet(q, 1, 0, ST_OK, 0, 0, 1);     // frame with no payload
    send_packet(q);
    build_packet(q, 1, 2, ST_OK, 0, 0, 4);
    send_packet(q);
    build_packet(q, 2, 1, ST_OK, 0, 0, 0);     // frame ends exactly at the end
    send_packet(q);
  endtask

  task automatic test_frame_faults();
    byte_queue_t q;
    build_packet(q, 2, 1, ST_BAD_HEADER, 1, 0, 2);
    send_packet(q);
    build_packet(q, 2, 2, ST_NO_BEGIN, 0, 0, 1);
    send_packet(q);
    build_packet(q, 1, 1, ST_BAD_LENGTH, 0, 2, 3);
    send_packet(q);
    build_packet(q, 1, 1, ST_BAD_LENGTH, 0, 0, 3);
    send_packet(q);
    build_packet(q, 2, 1, ST_BAD_LENGTH, 1, 16'hffff, 1);
    send_packet(q);
    build_packet(q, 1, 2, ST_BAD_LENGTH, 0, -1, 0);   // one word past the end
    send_packet(q);
    build_packet(q, 2, 3, ST_NO_COOKIE, 1, 0, 1);
    send_packet(q);
    build_packet(q, 1, 2, ST_NO_END, 0, 0, 2);
    send_packet(q);
  endtask

  task automatic test_packet_boundaries();
    byte_queue_t q;
    build_packet(q, 2, 2, ST_OK, 0, 0, 1);
    send_packet(q, -1, q.size() / 2);          // cut off by the next start
    build_packet(q, 2, 1, ST_OK, 0, 0, 0);
    send_packet(q, 23);                        // declared short: rest ignored
    build_packet(q, 1, 1, ST_OK, 0, 0, 1);
    send_packet(q, q.size() + 40);             // declared long: left hanging
    build_packet(q, 1, 3, ST_OK, 0, 0, 2);
    send_packet(q);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    byte_queue_t q;
    int          target, r, nfr, bad_len;
    logic [2:0]  fault;
    bit          drained;
    target  = packet_bytes_sent + RANDOM_BYTES;
    drained = 1'b0;
    while (packet_bytes_sent < target) begin
      tx_quiet = ($urandom_range(4) == 0);
      rx_quiet = ($urandom_range(4) == 0);
      if (!drained && packet_bytes_sent > target - RANDOM_BYTES / 2) begin
        wait_results_drained();
        drained = 1'b1;
      end
      nfr = $urandom_range(3, 1);
      r   = $urandom_range(99);
      if (r < 70) begin
        fault = ST_OK;
        if ($urandom_range(3) == 0) begin
          case ($urandom_range(4))
            0: fault = ST_BAD_HEADER;
            1: fault = ST_NO_BEGIN;
            2: fault = ST_BAD_LENGTH;
            3: fault = ST_NO_COOKIE;
            default: fault = ST_NO_END;
          endcase
        end
        case ($urandom_range(3))
          0: bad_len = $urandom_range(2);
          1: bad_len = 16'hffff;
          2: bad_len = $urandom_range(65535);
          default: bad_len = -1;
        endcase
        build_packet(q, nfr, -1, fault, $urandom_range(nfr - 1), bad_len,
                     $urandom_range(4));
        send_packet(q);
      end else if (r < 78) begin
        build_packet(q, nfr, -1, ST_OK, 0, 0, $urandom_range(4));
        send_packet(q, -1, $urandom_range(q.size() - 1, 1));
      end else if (r < 85) begin
        q.delete();
        q.push_back($urandom_range(1) ? START_BYTE : 8'($urandom));
        repeat ($urandom_range(30)) q.push_back(8'($urandom));
        send_packet(q, $urandom_range(1) ? $urandom_range(60, 0)
                                         : $urandom_range(65535));
      end else if (r < 93) begin
        build_packet(q, nfr, -1, ST_OK, 0, 0, $urandom_range(4));
        send_packet(q, q.size() + $urandom_range(8) - 4);
      end else begin
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom), 1'b0, 16'($urandom));
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    data_byte     = 8'd0;
    packet_start  = 1'b0;
    packet_length = 16'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_start_checks();
    test_well_formed_frames();
    test_frame_faults();
    test_packet_boundaries();
    test_random_traffic();

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
